>>> src/ipa_pkg.sv
// Shared types, constants and operation codes for the ID pool allocator.
package ipa_pkg;

    localparam int NUM_IDS_DEF = 256;
    localparam int CELL_W_DEF  = 64;
    localparam int POS_W       = 13;
    localparam int CNT_W       = 13;

    localparam logic [2:0] KIND_ALLOC      = 3'd0;
    localparam logic [2:0] KIND_FREE_ID    = 3'd1;
    localparam logic [2:0] KIND_QUERY_ID   = 3'd2;
    localparam logic [2:0] KIND_MARK_USED  = 3'd3;
    localparam logic [2:0] KIND_MARK_FREE  = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] id;
        logic [8:0] range_end;
        logic       report_free;
    } t_req;

    typedef struct packed {
        logic [7:0] result_id;
        logic       ok;
        logic [8:0] pool_count;
    } t_rsp;

    typedef struct packed {
        logic             valid;
        logic             scan;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        logic             set_val;
        logic             probe;
        logic             hit;
        logic             any_used;
        logic [POS_W-1:0] low_used;
        logic             any_free;
        logic [POS_W-1:0] first_free;
        logic [CNT_W-1:0] cnt;
    } t_tok;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } t_state;

endpackage

>>> src/ipa_cell.sv
// One bitmap cell: holds a slice of the used map and updates the passing token.
module ipa_cell import ipa_pkg::*; #(
    parameter int CELL_W  = CELL_W_DEF,
    parameter int BASE    = 0,
    parameter int NUM_IDS = NUM_IDS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_tok i_tok,
    output t_tok o_tok
);

    logic [CELL_W-1:0] r_word;
    logic [CELL_W-1:0] n_word;
    t_tok              r_tok;
    t_tok              n_tok;

    always_comb begin
        logic [POS_W-1:0] g;
        logic             lu_f;
        logic             ff_f;
        logic [POS_W-1:0] lu;
        logic [POS_W-1:0] ff;
        n_word = r_word;
        n_tok  = i_tok;
        lu_f   = 1'b0;
        ff_f   = 1'b0;
        lu     = '0;
        ff     = '0;
        for (int j = CELL_W - 1; j >= 0; j--) begin
            g = POS_W'(BASE + j);
            if (r_word[j]) begin
                lu_f = 1'b1;
                lu   = g;
            end
            if (!r_word[j] && (BASE + j < NUM_IDS)) begin
                ff_f = 1'b1;
                ff   = g;
            end
            if (i_tok.valid && !i_tok.scan && (g >= i_tok.lo) && (g < i_tok.hi)) begin
                n_word[j] = i_tok.set_val;
            end
            if (i_tok.probe && (g == i_tok.lo) && r_word[j]) begin
                n_tok.hit = 1'b1;
            end
        end
        if (i_tok.scan && !i_tok.any_used && lu_f) begin
            n_tok.any_used = 1'b1;
            n_tok.low_used = lu;
        end
        if (i_tok.scan && !i_tok.any_free && ff_f) begin
            n_tok.any_free   = 1'b1;
            n_tok.first_free = ff;
        end
        n_tok.cnt = i_tok.cnt + CNT_W'($countones(n_word));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
            r_tok  <= '0;
        end else begin
            r_word <= n_word;
            r_tok  <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

>>> src/id_pool_allocator_top.sv
// ID pool allocator top: request control, chain of bitmap cells, result register.
// An allocate makes two passes through the chain of ceil(NUM_IDS / CELL_W) cells (scan pass,
// then update pass) before the strobe rises; other kinds make a single pass.
// Throughput: one transaction at a time; busy drops with the strobe, so the next transaction
// can be accepted from the strobe on.
// Reset: synchronous active-low reset clears the whole map; the receiver cannot stall.
module id_pool_allocator_top import ipa_pkg::*; #(
    parameter int NUM_IDS = NUM_IDS_DEF,
    parameter int CELL_W  = CELL_W_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_strobe,
    output t_rsp o_rsp
);

    localparam int NUM_CELLS = (NUM_IDS + CELL_W - 1) / CELL_W;

    t_tok w_tok [NUM_CELLS+1];

    t_state           r_state, n_state;
    t_req             r_req, n_req;
    t_tok             r_launch, n_launch;
    logic [POS_W-1:0] r_target, n_target;
    logic             r_alloc_ok, n_alloc_ok;
    logic             r_strobe, n_strobe;
    t_rsp             r_rsp, n_rsp;

    assign w_tok[0] = r_launch;

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        ipa_cell #(
            .CELL_W  (CELL_W),
            .BASE    (c * CELL_W),
            .NUM_IDS (NUM_IDS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[c]),
            .o_tok   (w_tok[c+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_launch <= n_launch;
            r_strobe <= n_strobe;
        end
        r_req      <= n_req;
        r_target   <= n_target;
        r_alloc_ok <= n_alloc_ok;
        r_rsp      <= n_rsp;
    end

    always_comb begin
        logic [POS_W-1:0] id_pos;
        logic [POS_W-1:0] rend;
        logic [CNT_W-1:0] cnt;
        t_tok             tail;
        n_state    = r_state;
        n_req      = r_req;
        n_launch   = '0;
        n_target   = r_target;
        n_alloc_ok = r_alloc_ok;
        n_strobe   = 1'b0;
        n_rsp      = r_rsp;
        tail       = w_tok[NUM_CELLS];
        id_pos     = POS_W'(i_req.id);
        rend       = (POS_W'(i_req.range_end) > POS_W'(NUM_IDS)) ?
                     POS_W'(NUM_IDS) : POS_W'(i_req.range_end);
        cnt        = tail.cnt;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req          = i_req;
                    n_launch.valid = 1'b1;
                    n_state        = ST_APPLY;
                    case (i_req.kind)
                        KIND_ALLOC: begin
                            n_launch.scan = 1'b1;
                            n_state       = ST_SCAN;
                        end
                        KIND_FREE_ID: begin
                            n_launch.lo    = id_pos;
                            n_launch.hi    = id_pos + POS_W'(1);
                            n_launch.probe = 1'b1;
                        end
                        KIND_QUERY_ID: begin
                            n_launch.lo    = id_pos;
                            n_launch.hi    = id_pos;
                            n_launch.probe = 1'b1;
                        end
                        KIND_MARK_USED: begin
                            n_launch.lo      = id_pos;
                            n_launch.hi      = rend;
                            n_launch.set_val = 1'b1;
                        end
                        KIND_MARK_FREE: begin
                            n_launch.lo = id_pos;
                            n_launch.hi = rend;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (tail.valid) begin
                    n_alloc_ok = 1'b1;
                    if (!tail.any_used) begin
                        n_target = '0;
                    end else if (tail.low_used != '0) begin
                        n_target = tail.low_used - POS_W'(1);
                    end else if (tail.any_free) begin
                        n_target = tail.first_free;
                    end else begin
                        n_target   = '0;
                        n_alloc_ok = 1'b0;
                    end
                    n_launch.valid   = 1'b1;
                    n_launch.lo      = n_target;
                    n_launch.hi      = n_alloc_ok ? n_target + POS_W'(1) : n_target;
                    n_launch.set_val = 1'b1;
                    n_state          = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (tail.valid) begin
                    n_strobe      = 1'b1;
                    n_rsp.ok      = 1'b0;
                    n_rsp.result_id = r_req.id;
                    case (r_req.kind)
                        KIND_ALLOC: begin
                            n_rsp.ok        = r_alloc_ok;
                            n_rsp.result_id = r_alloc_ok ? r_target[7:0] : 8'd0;
                        end
                        KIND_FREE_ID: begin
                            n_rsp.ok = tail.hit;
                        end
                        KIND_QUERY_ID: begin
                            n_rsp.ok = tail.hit;
                        end
                        default: begin
                        end
                    endcase
                    if (r_req.report_free) begin
                        cnt = CNT_W'(NUM_IDS) - tail.cnt;
                    end
                    n_rsp.pool_count = cnt[8:0];
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule
